// ===== hw/rtl/ptpd_pkg.sv =====
// Package for the pressure trend phase detector.
// Holds field widths, register indexes, the shared multiplier command type and the
// sequencer states. It has no dependencies.
package ptpd_pkg;

    // Item field and configuration widths.
    localparam int SAMPLE_W    = 24;
    localparam int THRESH_W    = 23;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MAGNITUDE_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_LEVEL     = 1'b1;

    // Reset value of the threshold register: 10.0 in unsigned Q15.8.
    localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd2560;

    // Signed difference of two samples and its magnitude.
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int MAG_W  = SAMPLE_W;

    // Shared multiplier operand, product and accumulator widths.
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 25;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 64;
    localparam int HI_SHIFT = 32;

    // Sum of up to 31 squared differences, each below 2^48.
    localparam int SUMSQ_W = 53;

    // Commands for the shared multiply-accumulate unit.
    typedef enum logic [2:0] {
        MAC_HOLD,
        MAC_CLEAR,
        MAC_LOAD,
        MAC_ACC,
        MAC_ACC_HI
    } t_mac_op;

    typedef struct packed {
        t_mac_op              op;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
    } t_mac_req;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_PREP,
        ST_LHS_A,
        ST_LHS_B,
        ST_M2,
        ST_RHS_A,
        ST_RHS_B,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/ptpd_sample_if.sv =====
// Input channel of the pressure trend phase detector: one pressure sample per item.
// Depends on ptpd_pkg for the sample width.
interface ptpd_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ptpd_pkg::SAMPLE_W-1:0]   pressure_sample;

    modport source (output valid, output pressure_sample, input ready);
    modport sink   (input valid, input pressure_sample, output ready);
endinterface

// ===== hw/rtl/ptpd_result_if.sv =====
// Output channel of the pressure trend phase detector: one set of trend flags per item.
// Has no dependencies.
interface ptpd_result_if;
    logic valid;
    logic ready;
    logic window_ready;
    logic rising_detected;
    logic falling_detected;

    modport source (output valid, output window_ready, output rising_detected,
                    output falling_detected, input ready);
    modport sink   (input valid, input window_ready, input rising_detected,
                    input falling_detected, output ready);
endinterface

// ===== hw/rtl/ptpd_window.sv =====
// Circular sample store of the pressure trend phase detector.
// One write port and one registered read port; depends on ptpd_pkg for the sample width.
module ptpd_window #(
    parameter  int DEPTH = 10,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [AW-1:0]                          i_waddr,
    input  logic signed [ptpd_pkg::SAMPLE_W-1:0]   i_wdata,
    input  logic [AW-1:0]                          i_raddr,
    output logic signed [ptpd_pkg::SAMPLE_W-1:0]   o_rdata
);

    logic signed [ptpd_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [ptpd_pkg::SAMPLE_W-1:0] r_rdata;

    // Write on demand; read every cycle with the data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ptpd_mac.sv =====
// Shared multiply-accumulate unit of the pressure trend phase detector.
// A 32 by 25 bit multiplier feeding a 64-bit accumulator; depends on ptpd_pkg.
module ptpd_mac (
    input  logic                              i_clk,
    input  ptpd_pkg::t_mac_req                i_req,
    output logic [ptpd_pkg::ACC_W-1:0]        o_acc
);

    localparam int AccW = ptpd_pkg::ACC_W;
    localparam int ProdW = ptpd_pkg::MUL_P_W;
    localparam int HiShift = ptpd_pkg::HI_SHIFT;

    logic [ProdW-1:0] w_prod;
    logic [AccW-1:0]  r_acc;
    logic [AccW-1:0]  n_acc;

    assign w_prod = ProdW'(i_req.a) * ProdW'(i_req.b);

    // Accumulator update; the high form adds the product shifted up by one word.
    always_comb begin
        n_acc = r_acc;
        unique case (i_req.op)
            ptpd_pkg::MAC_CLEAR:  n_acc = '0;
            ptpd_pkg::MAC_LOAD:   n_acc = AccW'(w_prod);
            ptpd_pkg::MAC_ACC:    n_acc = r_acc + AccW'(w_prod);
            ptpd_pkg::MAC_ACC_HI: n_acc = r_acc
                                        + {w_prod[AccW-HiShift-1:0], {HiShift{1'b0}}};
            default:              n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/ptpd_ctrl.sv =====
// Sequencer and datapath registers of the pressure trend phase detector.
// Walks the sample store, drives the shared multiply-accumulate unit and holds the
// result item; depends on ptpd_pkg, ptpd_sample_if and ptpd_result_if.
module ptpd_ctrl #(
    parameter  int WINDOW_DEPTH = 10,
    parameter  int MIN_FILL     = 5,
    localparam int AW           = $clog2(WINDOW_DEPTH)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    ptpd_sample_if.sink                            i_sample,
    ptpd_result_if.source                          o_result,
    input  logic [ptpd_pkg::THRESH_W-1:0]          i_mag_threshold,
    input  logic signed [ptpd_pkg::SAMPLE_W-1:0]   i_ref_level,
    output logic                                   o_win_we,
    output logic [AW-1:0]                          o_win_waddr,
    output logic signed [ptpd_pkg::SAMPLE_W-1:0]   o_win_wdata,
    output logic [AW-1:0]                          o_win_raddr,
    input  logic signed [ptpd_pkg::SAMPLE_W-1:0]   i_win_rdata,
    output ptpd_pkg::t_mac_req                     o_mac_req,
    input  logic [ptpd_pkg::ACC_W-1:0]             i_mac_acc
);

    localparam int FW     = $clog2(WINDOW_DEPTH + 1);
    localparam int SW     = ptpd_pkg::SAMPLE_W;
    localparam int DW     = ptpd_pkg::DIFF_W;
    localparam int MW     = ptpd_pkg::MAG_W;
    localparam int MAW    = ptpd_pkg::MUL_A_W;
    localparam int MBW    = ptpd_pkg::MUL_B_W;
    localparam int QW     = ptpd_pkg::SUMSQ_W;
    localparam int AccW   = ptpd_pkg::ACC_W;
    localparam int HiS    = ptpd_pkg::HI_SHIFT;
    localparam int M2W    = 2 * FW;
    localparam bit MinOk  = (MIN_FILL <= WINDOW_DEPTH);
    localparam logic [AW-1:0] LastIdx   = AW'(WINDOW_DEPTH - 1);
    localparam logic [FW-1:0] DepthCnt  = FW'(WINDOW_DEPTH);
    localparam logic [FW-1:0] MinCnt    = FW'(MinOk ? MIN_FILL : 0);

    // Control state.
    ptpd_pkg::t_state r_state, n_state;
    logic [FW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_base, n_base;
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [FW-1:0]    r_rcnt, n_rcnt;
    logic             r_rv, n_rv;
    logic             r_rfirst, n_rfirst;
    logic             r_dv, n_dv;
    logic             r_ovld, n_ovld;

    // Datapath registers.
    logic signed [SW-1:0] r_new, n_new;
    logic signed [SW-1:0] r_oldest, n_oldest;
    logic signed [SW-1:0] r_prev, n_prev;
    logic [MW-1:0]        r_absd, n_absd;
    logic [QW-1:0]        r_q, n_q;
    logic [MW-1:0]        r_abs_s, n_abs_s;
    logic                 r_pos, n_pos;
    logic                 r_neg, n_neg;
    logic                 r_far, n_far;
    logic [AccW-1:0]      r_lhs, n_lhs;
    logic [M2W-1:0]       r_m2, n_m2;
    logic [FW-1:0]        r_m, n_m;
    logic                 r_wready, n_wready;
    logic                 r_rise, n_rise;
    logic                 r_fall, n_fall;
    logic                 r_o_wready, n_o_wready;
    logic                 r_o_rise, n_o_rise;
    logic                 r_o_fall, n_o_fall;

    // Combinational helpers.
    logic                 w_accept;
    logic [AW-1:0]        w_base_inc;
    logic signed [DW-1:0] w_diff;
    logic signed [DW-1:0] w_sum;
    logic signed [DW-1:0] w_dist;
    logic [MW-1:0]        w_abs_sum;
    logic [MW-1:0]        w_abs_dist;
    logic [FW:0]          w_two_m1;

    assign i_sample.ready   = (r_state == ptpd_pkg::ST_IDLE);
    assign w_accept         = i_sample.valid && i_sample.ready;
    assign o_result.valid            = r_ovld;
    assign o_result.window_ready     = r_o_wready;
    assign o_result.rising_detected  = r_o_rise;
    assign o_result.falling_detected = r_o_fall;

    assign w_base_inc = (r_base == LastIdx) ? '0 : r_base + 1'b1;

    // Successive difference, telescoped sum and distance from the reference.
    assign w_diff     = DW'(i_win_rdata) - DW'(r_prev);
    assign w_sum      = DW'(r_new) - DW'(r_oldest);
    assign w_dist     = DW'(i_ref_level) - DW'(r_oldest);
    assign w_abs_sum  = w_sum[DW-1]  ? MW'(-w_sum)  : MW'(w_sum);
    assign w_abs_dist = w_dist[DW-1] ? MW'(-w_dist) : MW'(w_dist);
    assign w_two_m1   = {r_m, 1'b0} - 1'b1;

    // Sample store ports.
    assign o_win_we    = w_accept;
    assign o_win_waddr = r_wptr;
    assign o_win_wdata = i_sample.pressure_sample;
    assign o_win_raddr = r_rptr;

    // Next state, datapath updates and multiplier commands.
    always_comb begin
        logic signed [DW-1:0] v_neg_diff;
        v_neg_diff = -w_diff;

        n_state    = r_state;
        n_fill     = r_fill;
        n_base     = r_base;
        n_wptr     = r_wptr;
        n_rptr     = r_rptr;
        n_rcnt     = r_rcnt;
        n_rv       = 1'b0;
        n_rfirst   = r_rfirst;
        n_dv       = 1'b0;
        n_ovld     = r_ovld;
        n_new      = r_new;
        n_oldest   = r_oldest;
        n_prev     = r_prev;
        n_absd     = r_absd;
        n_q        = r_q;
        n_abs_s    = r_abs_s;
        n_pos      = r_pos;
        n_neg      = r_neg;
        n_far      = r_far;
        n_lhs      = r_lhs;
        n_m2       = r_m2;
        n_m        = r_m;
        n_wready   = r_wready;
        n_rise     = r_rise;
        n_fall     = r_fall;
        n_o_wready = r_o_wready;
        n_o_rise   = r_o_rise;
        n_o_fall   = r_o_fall;
        o_mac_req  = '{op: ptpd_pkg::MAC_HOLD, a: '0, b: '0};

        // The result register empties when the receiver takes the item.
        if (r_ovld && o_result.ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            ptpd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_new  = i_sample.pressure_sample;
                    n_wptr = (r_wptr == LastIdx) ? '0 : r_wptr + 1'b1;
                    if (r_fill == DepthCnt) begin
                        n_base = w_base_inc;
                        n_rptr = w_base_inc;
                        n_fill = r_fill;
                    end else begin
                        n_rptr = r_base;
                        n_fill = r_fill + 1'b1;
                    end
                    n_m      = n_fill - 1'b1;
                    n_wready = MinOk && (n_fill >= MinCnt);
                    n_rcnt   = '0;
                    if (n_wready) begin
                        o_mac_req.op = ptpd_pkg::MAC_CLEAR;
                        n_state      = ptpd_pkg::ST_DIFF;
                    end else begin
                        n_rise  = 1'b0;
                        n_fall  = 1'b0;
                        n_state = ptpd_pkg::ST_DONE;
                    end
                end
            end

            ptpd_pkg::ST_DIFF: begin
                // Issue reads oldest to newest.
                if (r_rcnt != r_fill) begin
                    n_rptr   = (r_rptr == LastIdx) ? '0 : r_rptr + 1'b1;
                    n_rcnt   = r_rcnt + 1'b1;
                    n_rv     = 1'b1;
                    n_rfirst = (r_rcnt == '0);
                end
                // Take read data: the oldest sample, or one more difference.
                if (r_rv) begin
                    n_prev = i_win_rdata;
                    if (r_rfirst) begin
                        n_oldest = i_win_rdata;
                    end else begin
                        n_absd = w_diff[DW-1] ? MW'(v_neg_diff) : MW'(w_diff);
                        n_dv   = 1'b1;
                    end
                end
                // Square and add one difference.
                if (r_dv) begin
                    o_mac_req = '{op: ptpd_pkg::MAC_ACC, a: MAW'(r_absd), b: MBW'(r_absd)};
                end
                if (r_rcnt == r_fill && !r_rv && !r_dv) begin
                    n_state = ptpd_pkg::ST_PREP;
                end
            end

            ptpd_pkg::ST_PREP: begin
                n_q     = i_mac_acc[QW-1:0];
                n_abs_s = w_abs_sum;
                n_neg   = w_sum[DW-1];
                n_pos   = !w_sum[DW-1] && (w_sum != '0);
                n_far   = w_abs_dist > MW'(i_mag_threshold);
                n_state = ptpd_pkg::ST_LHS_A;
            end

            ptpd_pkg::ST_LHS_A: begin
                // |S| * (2m - 1)
                o_mac_req = '{op: ptpd_pkg::MAC_LOAD, a: MAW'(r_abs_s), b: MBW'(w_two_m1)};
                n_state   = ptpd_pkg::ST_LHS_B;
            end

            ptpd_pkg::ST_LHS_B: begin
                // |S| * (2m - 1) * |S|
                o_mac_req = '{op: ptpd_pkg::MAC_LOAD, a: i_mac_acc[MAW-1:0],
                              b: MBW'(r_abs_s)};
                n_state   = ptpd_pkg::ST_M2;
            end

            ptpd_pkg::ST_M2: begin
                n_lhs     = i_mac_acc;
                o_mac_req = '{op: ptpd_pkg::MAC_LOAD, a: MAW'(r_m), b: MBW'(r_m)};
                n_state   = ptpd_pkg::ST_RHS_A;
            end

            ptpd_pkg::ST_RHS_A: begin
                // Low word of Q times m squared.
                n_m2      = i_mac_acc[M2W-1:0];
                o_mac_req = '{op: ptpd_pkg::MAC_LOAD, a: r_q[MAW-1:0],
                              b: MBW'(i_mac_acc[M2W-1:0])};
                n_state   = ptpd_pkg::ST_RHS_B;
            end

            ptpd_pkg::ST_RHS_B: begin
                // High part of Q times m squared, added one word up.
                o_mac_req = '{op: ptpd_pkg::MAC_ACC_HI, a: MAW'(r_q[QW-1:HiS]),
                              b: MBW'(r_m2)};
                n_state   = ptpd_pkg::ST_CMP;
            end

            ptpd_pkg::ST_CMP: begin
                n_rise  = r_pos && r_far && (r_lhs > i_mac_acc);
                n_fall  = r_neg && r_far && (r_lhs > i_mac_acc);
                n_state = ptpd_pkg::ST_DONE;
            end

            ptpd_pkg::ST_DONE: begin
                // Hand the item over once the result register is free.
                if (!r_ovld || o_result.ready) begin
                    n_ovld     = 1'b1;
                    n_o_wready = r_wready;
                    n_o_rise   = r_rise;
                    n_o_fall   = r_fall;
                    n_state    = ptpd_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ptpd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ptpd_pkg::ST_IDLE;
            r_fill   <= '0;
            r_base   <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_rcnt   <= '0;
            r_rv     <= 1'b0;
            r_rfirst <= 1'b0;
            r_dv     <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_base   <= n_base;
            r_wptr   <= n_wptr;
            r_rptr   <= n_rptr;
            r_rcnt   <= n_rcnt;
            r_rv     <= n_rv;
            r_rfirst <= n_rfirst;
            r_dv     <= n_dv;
            r_ovld   <= n_ovld;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_new      <= n_new;
        r_oldest   <= n_oldest;
        r_prev     <= n_prev;
        r_absd     <= n_absd;
        r_q        <= n_q;
        r_abs_s    <= n_abs_s;
        r_pos      <= n_pos;
        r_neg      <= n_neg;
        r_far      <= n_far;
        r_lhs      <= n_lhs;
        r_m2       <= n_m2;
        r_m        <= n_m;
        r_wready   <= n_wready;
        r_rise     <= n_rise;
        r_fall     <= n_fall;
        r_o_wready <= n_o_wready;
        r_o_rise   <= n_o_rise;
        r_o_fall   <= n_o_fall;
    end

endmodule

// ===== hw/rtl/pressure_trend_phase_detector.sv =====
// Pressure trend phase detector: top level with the configuration registers.
// Instantiates ptpd_window, ptpd_mac and ptpd_ctrl; depends on ptpd_pkg and the
// ptpd_sample_if and ptpd_result_if interfaces.
//
// Usage: i_sample carries one signed Q16.8 pressure sample per item; o_result
// returns one item per sample with window_ready, rising_detected and
// falling_detected. An item moves when valid and ready are both high.
// The configuration port writes magnitude_threshold (index 0) or reference_level
// (index 1) at any edge with i_cfg_we high; write only while no item is in flight.
// Timing: the block takes one sample at a time. Until MIN_FILL samples are held an
// item goes from acceptance through the done state back to ready. After that the
// window is walked through the single read port of the sample store, and all
// products go through one shared multiplier before the compare and done states.
// Reset empties the window and restores the register defaults (threshold 10.0,
// reference 0.0). A stalled receiver holds the result in the output register;
// the next sample is still accepted and computed, and waits only to be delivered.
module pressure_trend_phase_detector #(
    parameter int WINDOW_DEPTH = 10,
    parameter int MIN_FILL     = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    ptpd_sample_if.sink                            i_sample,
    ptpd_result_if.source                          o_result,
    input  logic                                   i_cfg_we,
    input  logic [ptpd_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [ptpd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int TW = ptpd_pkg::THRESH_W;

    logic [TW-1:0]                        r_mag_threshold, n_mag_threshold;
    logic signed [ptpd_pkg::SAMPLE_W-1:0] r_ref_level, n_ref_level;

    logic                                 w_win_we;
    logic [AW-1:0]                        w_win_waddr;
    logic signed [ptpd_pkg::SAMPLE_W-1:0] w_win_wdata;
    logic [AW-1:0]                        w_win_raddr;
    logic signed [ptpd_pkg::SAMPLE_W-1:0] w_win_rdata;
    ptpd_pkg::t_mac_req                   w_mac_req;
    logic [ptpd_pkg::ACC_W-1:0]           w_mac_acc;

    // Configuration register writes.
    always_comb begin
        n_mag_threshold = r_mag_threshold;
        n_ref_level     = r_ref_level;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                ptpd_pkg::REG_MAGNITUDE_THRESHOLD: n_mag_threshold = i_cfg_data[TW-1:0];
                ptpd_pkg::REG_REFERENCE_LEVEL:     n_ref_level     = signed'(i_cfg_data);
                default: begin
                    n_mag_threshold = r_mag_threshold;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_threshold <= ptpd_pkg::THRESH_RESET;
            r_ref_level     <= '0;
        end else begin
            r_mag_threshold <= n_mag_threshold;
            r_ref_level     <= n_ref_level;
        end
    end

    // Sample store.
    ptpd_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_win_we),
        .i_waddr (w_win_waddr),
        .i_wdata (w_win_wdata),
        .i_raddr (w_win_raddr),
        .o_rdata (w_win_rdata)
    );

    // Shared multiply-accumulate unit.
    ptpd_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_mac_req),
        .o_acc (w_mac_acc)
    );

    // Sequencer.
    ptpd_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MIN_FILL     (MIN_FILL)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample        (i_sample),
        .o_result        (o_result),
        .i_mag_threshold (r_mag_threshold),
        .i_ref_level     (r_ref_level),
        .o_win_we        (w_win_we),
        .o_win_waddr     (w_win_waddr),
        .o_win_wdata     (w_win_wdata),
        .o_win_raddr     (w_win_raddr),
        .i_win_rdata     (w_win_rdata),
        .o_mac_req       (w_mac_req),
        .i_mac_acc       (w_mac_acc)
    );

endmodule
